/* src/skjs_pkg.sv */
// Shared types and constants for the sorted key table with cell-chain lookup.
// Used by the channel interfaces, the table cell and the top level.
package skjs_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned HandleW = 16;
  localparam int unsigned PosW    = 7;

  typedef enum logic {
    ModeInsert = 1'b0,
    ModeSearch = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StFound    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  // Search item moving down the cell chain, one cell per cycle.
  // smaller counts modulo 2**PosW, which matches the width of the position field.
  typedef struct packed {
    logic               active;
    logic [KeyW-1:0]    key;
    logic [PosW-1:0]    smaller;
    logic               hit;
    logic [HandleW-1:0] handle;
  } wave_t;

endpackage

/* src/skjs_if.sv */
// Request and response channel interfaces (valid/ready) of the key table.
// Depends on skjs_pkg for field widths.
interface skjs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [skjs_pkg::KeyW-1:0]    key;
  logic [skjs_pkg::HandleW-1:0] handle;

  modport source (output valid, output mode, output key, output handle, input ready);
  modport sink   (input valid, input mode, input key, input handle, output ready);
endinterface

interface skjs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [skjs_pkg::PosW-1:0]    sorted_position;
  logic [skjs_pkg::HandleW-1:0] found_handle;
  logic [skjs_pkg::PosW-1:0]    entry_total;

  modport source (output valid, output status, output sorted_position,
                  output found_handle, output entry_total, input ready);
  modport sink   (input valid, input status, input sorted_position,
                  input found_handle, input entry_total, output ready);
endinterface

/* src/skjs_cell.sv */
// One table cell: holds one key/handle entry and folds it into a passing search item.
// Depends on skjs_pkg for the search item type.
module skjs_cell #(
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CNT_W-1:0]             count_i,
  input  logic                         wr_i,
  input  logic [skjs_pkg::KeyW-1:0]    wr_key_i,
  input  logic [skjs_pkg::HandleW-1:0] wr_handle_i,
  input  skjs_pkg::wave_t              wave_i,
  output skjs_pkg::wave_t              wave_o
);

  logic [skjs_pkg::KeyW-1:0]    key_q;
  logic [skjs_pkg::HandleW-1:0] handle_q;
  skjs_pkg::wave_t              wave_d, wave_q;
  logic                         holds;

  // Entries fill in arrival order, so this cell is live once the count passes it.
  assign holds = CNT_W'(CELL_IDX) < count_i;

  always_ff @(posedge clk_i) begin
    if (wr_i && (count_i == CNT_W'(CELL_IDX))) begin
      key_q    <= wr_key_i;
      handle_q <= wr_handle_i;
    end
  end

  always_comb begin
    wave_d = wave_i;
    if (wave_i.active && holds) begin
      if (key_q < wave_i.key) begin
        wave_d.smaller = wave_i.smaller + skjs_pkg::PosW'(1);
      end else if ((key_q == wave_i.key) && !wave_i.hit) begin
        // cells are visited in insert order: first hit is the earliest match
        wave_d.hit    = 1'b1;
        wave_d.handle = handle_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

/* src/sorted_key_table_jump_search.sv */
// Sorted key table with ordered lookup: a chain of CAPACITY cells, one entry each.
// Depends on skjs_pkg, skjs_if (request/response interfaces) and skjs_cell.
//
// Usage:
//   req_i carries mode, key and handle; an item is taken when valid and ready
//   are both high. rsp_o returns one item per request: status, sorted position
//   (count of held keys below the key, on a hit), handle of the earliest match
//   and the number of entries held afterwards.
//   Insert: result is registered at accept and shows on the next cycle; inserts
//   can follow each other every cycle while the response side keeps up.
//   Search: the item walks the cell chain one cell per cycle, through the
//   CAPACITY cell registers, and its result is then registered on the output.
//   Requests are held off while a search is in the chain.
//   One response register sits on the output; while it holds an item the
//   receiver has not taken, no request is accepted.
//   Reset empties the table (count to zero) and clears all valid flags; the
//   stored keys and handles are not cleared and are never read before written.
module sorted_key_table_jump_search #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skjs_req_if.sink   req_i,
  skjs_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_d, count_q;
  logic             busy_d, busy_q;
  logic             rsp_valid_d, rsp_valid_q;
  logic             req_ready, accept, ins, srch, full, wr;

  skjs_pkg::status_e            status_d, status_q;
  logic [skjs_pkg::PosW-1:0]    pos_d, pos_q;
  logic [skjs_pkg::HandleW-1:0] fh_d, fh_q;
  logic [skjs_pkg::PosW-1:0]    total_d, total_q;

  skjs_pkg::wave_t wave [CAPACITY+1];
  skjs_pkg::wave_t tail;

  assign req_ready = !busy_q && (!rsp_valid_q || rsp_o.ready);
  assign accept    = req_i.valid && req_ready;
  assign ins       = accept && (req_i.mode == skjs_pkg::ModeInsert);
  assign srch      = accept && (req_i.mode == skjs_pkg::ModeSearch);
  assign full      = count_q == CNT_W'(CAPACITY);
  assign wr        = ins && !full;

  always_comb begin
    wave[0]         = '0;
    wave[0].active  = srch;
    wave[0].key     = req_i.key;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skjs_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .count_i     (count_q),
      .wr_i        (wr),
      .wr_key_i    (req_i.key),
      .wr_handle_i (req_i.handle),
      .wave_i      (wave[i]),
      .wave_o      (wave[i+1])
    );
  end

  assign tail = wave[CAPACITY];

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    rsp_valid_d = rsp_valid_q;
    status_d    = status_q;
    pos_d       = pos_q;
    fh_d        = fh_q;
    total_d     = total_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (wr) begin
      count_d = count_q + CNT_W'(1);
    end
    if (srch) begin
      busy_d = 1'b1;
    end

    if (ins) begin
      rsp_valid_d = 1'b1;
      status_d    = full ? skjs_pkg::StFull : skjs_pkg::StInserted;
      pos_d       = '0;
      fh_d        = '0;
      total_d     = skjs_pkg::PosW'(count_d);
    end else if (tail.active) begin
      busy_d      = 1'b0;
      rsp_valid_d = 1'b1;
      status_d    = tail.hit ? skjs_pkg::StFound : skjs_pkg::StNotFound;
      pos_d       = tail.hit ? tail.smaller : '0;
      fh_d        = tail.hit ? tail.handle : '0;
      total_d     = skjs_pkg::PosW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
    fh_q     <= fh_d;
    total_q  <= total_d;
  end

  assign req_i.ready           = req_ready;
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.sorted_position = pos_q;
  assign rsp_o.found_handle    = fh_q;
  assign rsp_o.entry_total     = total_q;

endmodule
